// File: rtl/core/utf8d_pkg.sv
// utf8d_pkg: shared types, constants and error codes of the utf-8 stream decoder
// depends on nothing; imported by every module of the decoder
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam int CP_W    = 31;
	localparam int CNT_W   = 32;
	localparam int ERR_W   = 4;
	localparam int REM_W   = 3;
	localparam int PADDR_W = 3;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE       = 4'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_START  = 4'd1;
	localparam logic [ERR_W-1:0] ERR_BAD_CONT   = 4'd2;
	localparam logic [ERR_W-1:0] ERR_INCOMPLETE = 4'd3;
	localparam logic [ERR_W-1:0] ERR_OVERLONG   = 4'd4;
	localparam logic [ERR_W-1:0] ERR_SURROGATE  = 4'd5;
	localparam logic [ERR_W-1:0] ERR_FFFE       = 4'd6;
	localparam logic [ERR_W-1:0] ERR_FFFF       = 4'd7;
	localparam logic [ERR_W-1:0] ERR_ABOVE_MAX  = 4'd8;

	// register indexes
	localparam logic [0:0] REG_CHECK_UNICODE = 1'b0;

	// smallest legal value of each multi-byte form
	localparam logic [CP_W-1:0] MIN_2B = 31'h0000_0080;
	localparam logic [CP_W-1:0] MIN_3B = 31'h0000_0800;
	localparam logic [CP_W-1:0] MIN_4B = 31'h0001_0000;
	localparam logic [CP_W-1:0] MIN_5B = 31'h0020_0000;
	localparam logic [CP_W-1:0] MIN_6B = 31'h0400_0000;

	localparam logic [CP_W-1:0] SURR_LO   = 31'h0000_D800;
	localparam logic [CP_W-1:0] SURR_HI   = 31'h0000_DFFF;
	localparam logic [CP_W-1:0] NONCH_E   = 31'h0000_FFFE;
	localparam logic [CP_W-1:0] NONCH_F   = 31'h0000_FFFF;
	localparam logic [CP_W-1:0] UNI_LIMIT = 31'h0011_0000;

	typedef struct packed {
		logic [CP_W-1:0]  acc;
		logic [REM_W-1:0] remaining;
		logic [CP_W-1:0]  minimum;
		logic [CNT_W-1:0] count;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [ERR_W-1:0] error_code;
		logic [CNT_W-1:0] count;
		logic             last;
	} dec_result_t;

	typedef struct packed {
		logic out_full;
		logic skid_full;
	} buf_status_t;

endpackage

// File: rtl/core/utf8d_decode.sv
// utf8d_decode: single-pass next-state and result logic for one byte
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_decode (
	input  utf8d_pkg::dec_state_t  state,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_string,
	input  logic                   check_unicode,
	output utf8d_pkg::dec_state_t  state_next,
	output logic                   has_result,
	output utf8d_pkg::dec_result_t result
);
	import utf8d_pkg::*;

	logic [CP_W-1:0]  shifted;
	logic [REM_W-1:0] rem_dec;
	logic [ERR_W-1:0] judged;
	logic [ERR_W-1:0] err;
	logic [CP_W-1:0]  cp;
	logic [CNT_W-1:0] count_inc;
	logic             emit;

	// accumulator with the next six payload bits shifted in
	assign shifted = {state.acc[CP_W-7:0], data_byte[5:0]};
	assign rem_dec = state.remaining - REM_W'(1);

	// checks on a completed multi-byte value
	always_comb begin
		judged = ERR_NONE;
		if (shifted < state.minimum) begin
			judged = ERR_OVERLONG;
		end else if (check_unicode) begin
			if (shifted >= SURR_LO && shifted <= SURR_HI) begin
				judged = ERR_SURROGATE;
			end else if (shifted == NONCH_E) begin
				judged = ERR_FFFE;
			end else if (shifted == NONCH_F) begin
				judged = ERR_FFFF;
			end else if (shifted >= UNI_LIMIT) begin
				judged = ERR_ABOVE_MAX;
			end
		end
	end

	// byte decode: start byte when idle, continuation byte otherwise
	always_comb begin
		state_next = state;
		emit       = 1'b0;
		err        = ERR_NONE;
		cp         = '0;
		if (state.remaining == '0) begin
			if (!data_byte[7]) begin
				emit = 1'b1;
				cp   = {{(CP_W-8){1'b0}}, data_byte};
			end else if (data_byte < 8'hC0 || data_byte >= 8'hFE) begin
				emit = 1'b1;
				err  = ERR_BAD_START;
			end else begin
				if (data_byte < 8'hE0) begin
					state_next.remaining = 3'd1;
					state_next.minimum   = MIN_2B;
					state_next.acc       = {{(CP_W-5){1'b0}}, data_byte[4:0]};
				end else if (data_byte < 8'hF0) begin
					state_next.remaining = 3'd2;
					state_next.minimum   = MIN_3B;
					state_next.acc       = {{(CP_W-4){1'b0}}, data_byte[3:0]};
				end else if (data_byte < 8'hF8) begin
					state_next.remaining = 3'd3;
					state_next.minimum   = MIN_4B;
					state_next.acc       = {{(CP_W-3){1'b0}}, data_byte[2:0]};
				end else if (data_byte < 8'hFC) begin
					state_next.remaining = 3'd4;
					state_next.minimum   = MIN_5B;
					state_next.acc       = {{(CP_W-2){1'b0}}, data_byte[1:0]};
				end else begin
					state_next.remaining = 3'd5;
					state_next.minimum   = MIN_6B;
					state_next.acc       = {{(CP_W-1){1'b0}}, data_byte[0]};
				end
				if (end_of_string) begin
					emit = 1'b1;
					err  = ERR_INCOMPLETE;
				end
			end
		end else if (data_byte[7:6] != 2'b10) begin
			emit = 1'b1;
			err  = ERR_BAD_CONT;
		end else begin
			state_next.acc       = shifted;
			state_next.remaining = rem_dec;
			if (rem_dec == '0) begin
				emit = 1'b1;
				err  = judged;
				cp   = (judged == ERR_NONE) ? shifted : '0;
			end else if (end_of_string) begin
				emit = 1'b1;
				err  = ERR_INCOMPLETE;
			end
		end

		// count is bumped by good code points and saturates
		count_inc = state.count;
		if (emit && err == ERR_NONE && state.count != '1) begin
			count_inc = state.count + CNT_W'(1);
		end

		if (emit) begin
			state_next.acc       = '0;
			state_next.remaining = '0;
			state_next.minimum   = '0;
			state_next.count     = end_of_string ? '0 : count_inc;
		end

		has_result        = emit;
		result.code_point = cp;
		result.error_code = err;
		result.count      = count_inc;
		result.last       = end_of_string;
	end

endmodule

// File: rtl/core/utf8d_out_buf.sv
// utf8d_out_buf: result register with a skid stage behind it
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  utf8d_pkg::dec_result_t push_data,
	output logic                   can_push,
	output logic                   out_valid,
	input  logic                   out_ready,
	output utf8d_pkg::dec_result_t out_data,
	output utf8d_pkg::buf_status_t status
);
	import utf8d_pkg::*;

	logic        out_valid_q;
	logic        skid_valid_q;
	dec_result_t out_q;
	dec_result_t skid_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign can_push         = !skid_valid_q;
	assign out_valid        = out_valid_q;
	assign out_data         = out_q;
	assign status.out_full  = out_valid_q;
	assign status.skid_full = skid_valid_q;

endmodule

// File: rtl/core/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: utf-8 stream decoder with apb register port
// depends on utf8d_pkg, utf8d_decode, utf8d_out_buf
`timescale 1ns / 1ps

// Decodes extended utf-8 (one- to six-byte forms) one byte per request and
// takes a new byte every clock cycle while in_ready is high: the decode of a
// byte is a single pass of logic between the sequence state registers and the
// result register. A result (code point or error code, running count, last
// flag) of the byte that completes or breaks a sequence goes into the result
// register, or into a one-entry skid stage while output stalls, so input can
// continue; in_ready drops only when both hold results. Errors return the
// decoder to idle; end_of_string always yields a result and clears the count.
// The check_unicode register (byte address 0, bit 0, reset 1) enables the
// surrogate, U+FFFE, U+FFFF and above-U+10FFFF checks; write it only while idle.

module utf8_stream_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// apb register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [utf8d_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// byte input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_string,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [utf8d_pkg::CP_W-1:0]    code_point,
	output logic [utf8d_pkg::ERR_W-1:0]   error_code,
	output logic [utf8d_pkg::CNT_W-1:0]   code_point_count,
	output logic                          last
);
	import utf8d_pkg::*;

	logic        check_unicode_q;
	dec_state_t  state_q;
	dec_state_t  state_next;
	logic        has_result;
	dec_result_t result;
	dec_result_t out_data;
	buf_status_t buf_status;
	logic        in_accept;
	logic        cfg_write;

	// register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CHECK_UNICODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_unicode_q <= 1'b1;
		end else if (cfg_write) begin
			check_unicode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_CHECK_UNICODE) ? {31'd0, check_unicode_q} : 32'd0;

	// sequence state
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_accept) begin
			state_q <= state_next;
		end
	end

	utf8d_decode u_decode (
		.state         (state_q),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.check_unicode (check_unicode_q),
		.state_next    (state_next),
		.has_result    (has_result),
		.result        (result)
	);

	// result register and skid stage
	utf8d_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept && has_result),
		.push_data (result),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.status    (buf_status)
	);

	assign code_point       = out_data.code_point;
	assign error_code       = out_data.error_code;
	assign code_point_count = out_data.count;
	assign last             = out_data.last;

	// skid stage only fills behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		buf_status.skid_full |-> buf_status.out_full)
		else $error("skid stage full while result register empty");

	// an error result carries no code point
	a_err_no_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_NONE) |-> (code_point == '0))
		else $error("error result with nonzero code point");

	// end of string leaves the decoder idle with a cleared count
	a_eos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && end_of_string) |=> (state_q.remaining == '0 && state_q.count == '0))
		else $error("decoder not idle after end of string");

	// error codes stay in the defined range
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code <= ERR_ABOVE_MAX))
		else $error("undefined error code");

endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for utf8_stream_decoder_top, directed rows then random strings
// depends on utf8d_pkg and utf8_stream_decoder_top; predicts each result and checks it in order
`timescale 1ns / 1ps

module testbench;
	import utf8d_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int ITEM_TARGET  = 1430;
	localparam int PHASE_ITEMS  = 170;
	localparam int IDLE_LAT     = 4;
	localparam int MAX_REPORTS  = 10;
	localparam logic [PADDR_W-1:0] CFG_ADDR = PADDR_W'({REG_CHECK_UNICODE, 2'b00});

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HOLD, RX_SPARSE} rx_mode_t;

	typedef struct {
		row_kind_t   kind;
		logic [7:0]  b;
		logic        eos;
		bit          typed;
		dec_result_t res;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte = '0;
	logic                end_of_string = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CP_W-1:0]     code_point;
	logic [ERR_W-1:0]    error_code;
	logic [CNT_W-1:0]    code_point_count;
	logic                last;

	// typed expectation travelling with the request
	bit                  tag_typed = 1'b0;
	dec_result_t         tag_res = '0;

	// decoder state as the bench sees it
	logic [CP_W-1:0]     seq_acc = '0;
	logic [REM_W-1:0]    seq_left = '0;
	logic [CP_W-1:0]     seq_min = '0;
	logic [CNT_W-1:0]    cp_count = '0;
	logic                uni_check = 1'b1;

	dec_result_t         pending_results[$];
	stim_row_t           stim_rows[$];
	logic [7:0]          str_bytes[$];
	int                  fail_cnt = 0;
	int                  items_sent = 0;
	int                  burst_left = 0;
	int                  cycle_cnt = 0;
	int                  rx_left = 0;
	rx_mode_t            rx_mode = RX_OPEN;

	utf8_stream_decoder_top DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_string(end_of_string),
		.out_valid(out_valid), .out_ready(out_ready),
		.code_point(code_point), .error_code(error_code),
		.code_point_count(code_point_count), .last(last)
	);

	always #10 clk = ~clk;

	function automatic void note_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	// completion checks in priority order
	function automatic logic [ERR_W-1:0] judge_value(input logic [CP_W-1:0] v);
		if (v < seq_min) return ERR_OVERLONG;
		if (uni_check) begin
			if (v >= SURR_LO && v <= SURR_HI) return ERR_SURROGATE;
			if (v == NONCH_E) return ERR_FFFE;
			if (v == NONCH_F) return ERR_FFFF;
			if (v >= UNI_LIMIT) return ERR_ABOVE_MAX;
		end
		return ERR_NONE;
	endfunction

	// build a result, go idle, clear the count at end of string
	task automatic close_seq(input logic [CP_W-1:0] v, input logic [ERR_W-1:0] e,
			input logic eos, output dec_result_t r);
		if (e == ERR_NONE) begin
			if (cp_count != '1) cp_count++;
			r.code_point = v;
		end else begin
			r.code_point = '0;
		end
		r.error_code = e;
		r.count = cp_count;
		r.last = eos;
		seq_acc = '0;
		seq_left = '0;
		seq_min = '0;
		if (eos) cp_count = '0;
	endtask

	// one byte through the decoder
	task automatic decode_byte(input logic [7:0] b, input logic eos, output bit got,
			output dec_result_t r);
		got = 1'b0;
		r = '0;
		if (seq_left == 0) begin
			if (b < 8'h80) begin
				close_seq(CP_W'(b), ERR_NONE, eos, r);
				got = 1'b1;
			end else if (b < 8'hC0 || b >= 8'hFE) begin
				close_seq('0, ERR_BAD_START, eos, r);
				got = 1'b1;
			end else begin
				casez (b)
					8'b110?????: begin
						seq_left = 3'd1; seq_min = MIN_2B; seq_acc = CP_W'(b[4:0]);
					end
					8'b1110????: begin
						seq_left = 3'd2; seq_min = MIN_3B; seq_acc = CP_W'(b[3:0]);
					end
					8'b11110???: begin
						seq_left = 3'd3; seq_min = MIN_4B; seq_acc = CP_W'(b[2:0]);
					end
					8'b111110??: begin
						seq_left = 3'd4; seq_min = MIN_5B; seq_acc = CP_W'(b[1:0]);
					end
					default: begin
						seq_left = 3'd5; seq_min = MIN_6B; seq_acc = CP_W'(b[0]);
					end
				endcase
				if (eos) begin
					close_seq('0, ERR_INCOMPLETE, eos, r);
					got = 1'b1;
				end
			end
		end else if (b[7:6] != 2'b10) begin
			close_seq('0, ERR_BAD_CONT, eos, r);
			got = 1'b1;
		end else begin
			seq_acc = {seq_acc[CP_W-7:0], b[5:0]};
			seq_left = seq_left - 3'd1;
			if (seq_left == 0) begin
				close_seq(seq_acc, judge_value(seq_acc), eos, r);
				got = 1'b1;
			end else if (eos) begin
				close_seq('0, ERR_INCOMPLETE, eos, r);
				got = 1'b1;
			end
		end
	endtask

	// watch both channels, predict on accepted requests, check accepted results
	always @(posedge clk) begin : watch
		bit got;
		dec_result_t r;
		dec_result_t want;
		dec_result_t seen;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				decode_byte(data_byte, end_of_string, got, r);
				if (got)
					pending_results.push_back(tag_typed ? tag_res : r);
			end
			if (out_valid && out_ready) begin
				seen.code_point = code_point;
				seen.error_code = error_code;
				seen.count = code_point_count;
				seen.last = last;
				if (pending_results.size() == 0) begin
					note_fail($sformatf("unexpected result cp %h err %0d cnt %0d last %0d",
						code_point, error_code, code_point_count, last));
				end else begin
					want = pending_results.pop_front();
					if (seen !== want)
						note_fail($sformatf(
							"mismatch: want cp %h err %0d cnt %0d last %0d, got cp %h err %0d cnt %0d last %0d",
							want.code_point, want.error_code, want.count, want.last,
							seen.code_point, seen.error_code, seen.count, seen.last));
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 10) : $urandom_range(8, 60);
		end
		rx_left = rx_left - 1;
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_HOLD: out_ready <= 1'b0;
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic stim_row_t row_byte(input logic [7:0] b, input logic eos);
		stim_row_t row;
		row.kind = ROW_BYTE;
		row.b = b;
		row.eos = eos;
		row.typed = 1'b0;
		row.res = '0;
		return row;
	endfunction

	function automatic stim_row_t row_check(input logic [7:0] b, input logic eos,
			input logic [CP_W-1:0] cp, input logic [ERR_W-1:0] err, input logic [CNT_W-1:0] cnt);
		stim_row_t row;
		row = row_byte(b, eos);
		row.typed = 1'b1;
		row.res.code_point = cp;
		row.res.error_code = err;
		row.res.count = cnt;
		row.res.last = eos;
		return row;
	endfunction

	function automatic stim_row_t row_cfg(input logic v);
		stim_row_t row;
		row = row_byte({7'b0, v}, 1'b0);
		row.kind = ROW_CFG;
		return row;
	endfunction

	// one request, with a random gap whenever a burst runs out
	task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed,
			input dec_result_t tr);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_string <= eos;
		tag_typed <= typed;
		tag_res <= tr;
		items_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// register write plus read-back, only while idle
	task automatic set_check_unicode(input logic v);
		wait_drained();
		repeat (IDLE_LAT) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR;
		pwdata <= {31'b0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		uni_check = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== v)
			note_fail($sformatf("check_unicode read back %0d, wrote %0d", prdata[0], v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// append a sequence of form n for value v, keeping only the first keep bytes
	task automatic push_seq(input logic [CP_W-1:0] v, input int n, input int keep);
		logic [7:0] seq [6];
		int k;
		if (n == 1) begin
			seq[0] = {1'b0, v[6:0]};
		end else begin
			seq[0] = 8'(8'hFF << (8 - n)) | 8'(v >> (6 * (n - 1)));
			for (k = 1; k < n; k++)
				seq[k] = 8'h80 | 8'((v >> (6 * (n - 1 - k))) & 31'h3F);
		end
		for (k = 0; k < keep; k++)
			str_bytes.push_back(seq[k]);
	endtask

	function automatic int pick_form();
		int w;
		w = $urandom_range(0, 15);
		if (w < 5) return 1;
		if (w < 9) return 2;
		if (w < 12) return 3;
		if (w < 14) return 4;
		if (w < 15) return 5;
		return 6;
	endfunction

	// value for a form: bounds, overlong, boundary values of the unicode checks
	function automatic logic [CP_W-1:0] pick_value(input int n);
		int unsigned lo;
		int unsigned hi;
		int unsigned s;
		case (n)
			1: lo = 0;
			2: lo = 32'(MIN_2B);
			3: lo = 32'(MIN_3B);
			4: lo = 32'(MIN_4B);
			5: lo = 32'(MIN_5B);
			default: lo = 32'(MIN_6B);
		endcase
		hi = (n == 1) ? 32'h7F : (32'd1 << (5 * n + 1)) - 1;
		case ($urandom_range(0, 7))
			0: return CP_W'(lo);
			1: return CP_W'((n > 1) ? lo - 1 : hi);
			2: return CP_W'((n > 1) ? $urandom_range(0, lo - 1) : 0);
			3: return CP_W'(hi);
			4: begin
				case ($urandom_range(0, 11))
					0: s = 32'(SURR_LO) - 1;
					1: s = 32'(SURR_LO);
					2: s = 32'hDBFF;
					3: s = 32'hDC00;
					4: s = 32'(SURR_HI);
					5: s = 32'(SURR_HI) + 1;
					6: s = 32'hFFFD;
					7: s = 32'(NONCH_E);
					8: s = 32'(NONCH_F);
					9: s = 32'(MIN_4B);
					10: s = 32'(UNI_LIMIT) - 1;
					default: s = 32'(UNI_LIMIT);
				endcase
				return CP_W'((s > hi) ? hi : s);
			end
			default: return CP_W'($urandom_range(lo, hi));
		endcase
	endfunction

	// mostly well-formed code points, with truncated sequences and stray bytes
	task automatic build_string();
		int nel;
		int i;
		int r;
		int n;
		str_bytes.delete();
		nel = $urandom_range(1, 10);
		for (i = 0; i < nel; i++) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				n = pick_form();
				push_seq(pick_value(n), n, n);
			end else if (r < 88) begin
				n = $urandom_range(2, 6);
				push_seq(pick_value(n), n, $urandom_range(1, n - 1));
			end else if (r < 95) begin
				str_bytes.push_back(8'($urandom));
			end else begin
				str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
		end
	endtask

	initial begin
		stim_row_t row;
		int idx;
		int phase;
		int start_cnt;
		int nstr;

		// directed rows, check_unicode on from reset
		stim_rows.push_back(row_check(8'h00, 1'b1, '0, ERR_NONE, 32'd1));
		stim_rows.push_back(row_check(8'h80, 1'b0, '0, ERR_BAD_START, 32'd0));
		stim_rows.push_back(row_check(8'hFF, 1'b0, '0, ERR_BAD_START, 32'd0));
		stim_rows.push_back(row_check(8'hFE, 1'b1, '0, ERR_BAD_START, 32'd0));
		stim_rows.push_back(row_byte(8'h7F, 1'b0));
		stim_rows.push_back(row_byte(8'hC2, 1'b0));
		stim_rows.push_back(row_byte(8'h80, 1'b0));
		// overlong two-byte form of 0x7f
		stim_rows.push_back(row_byte(8'hC1, 1'b0));
		stim_rows.push_back(row_check(8'hBF, 1'b1, '0, ERR_OVERLONG, 32'd2));
		// surrogate
		stim_rows.push_back(row_byte(8'hED, 1'b0));
		stim_rows.push_back(row_byte(8'hA0, 1'b0));
		stim_rows.push_back(row_check(8'h80, 1'b0, '0, ERR_SURROGATE, 32'd0));
		// u+fffe and u+ffff
		stim_rows.push_back(row_byte(8'hEF, 1'b0));
		stim_rows.push_back(row_byte(8'hBF, 1'b0));
		stim_rows.push_back(row_check(8'hBE, 1'b0, '0, ERR_FFFE, 32'd0));
		stim_rows.push_back(row_byte(8'hEF, 1'b0));
		stim_rows.push_back(row_byte(8'hBF, 1'b0));
		stim_rows.push_back(row_check(8'hBF, 1'b0, '0, ERR_FFFF, 32'd0));
		// 0x110000
		stim_rows.push_back(row_byte(8'hF4, 1'b0));
		stim_rows.push_back(row_byte(8'h90, 1'b0));
		stim_rows.push_back(row_byte(8'h80, 1'b0));
		stim_rows.push_back(row_check(8'h80, 1'b0, '0, ERR_ABOVE_MAX, 32'd0));
		// non-continuation byte inside a sequence is consumed
		stim_rows.push_back(row_byte(8'hC2, 1'b0));
		stim_rows.push_back(row_check(8'h41, 1'b0, '0, ERR_BAD_CONT, 32'd0));
		// string ends on a start byte
		stim_rows.push_back(row_check(8'hF0, 1'b1, '0, ERR_INCOMPLETE, 32'd0));
		// syntax only: largest six-byte value
		stim_rows.push_back(row_cfg(1'b0));
		stim_rows.push_back(row_byte(8'hFD, 1'b0));
		for (idx = 0; idx < 4; idx++)
			stim_rows.push_back(row_byte(8'hBF, 1'b0));
		stim_rows.push_back(row_check(8'hBF, 1'b1, {CP_W{1'b1}}, ERR_NONE, 32'd1));

		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part
		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_CFG)
				set_check_unicode(row.b[0]);
			else
				send_byte(row.b, row.eos, row.typed, row.res);
		end

		// random strings, alternating the register between phases
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			set_check_unicode(~phase[0]);
			start_cnt = items_sent;
			nstr = 0;
			while (items_sent - start_cnt < PHASE_ITEMS) begin
				build_string();
				for (idx = 0; idx < str_bytes.size(); idx++)
					send_byte(str_bytes[idx], idx == str_bytes.size() - 1, 1'b0, '0);
				nstr++;
				// hold the sender until the output side is empty
				if (nstr == 5)
					wait_drained();
			end
			phase++;
		end

		// drain and report
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_decode.sv
rtl/core/utf8d_out_buf.sv
rtl/core/utf8_stream_decoder_top.sv
verif/testbench.sv
